>>> hw/rtl/dns_message_parser_defines.svh
// Assertion macros shared by the DNS message parser RTL.
// Included by any module that carries concurrent checks; needs clk and rst_n in scope.
`ifndef DNS_MESSAGE_PARSER_DEFINES_SVH
`define DNS_MESSAGE_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked at every rising clk edge, off while rst_n is low.
`define DMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every rising clk edge, reset included.
`define DMP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DMP_ASSERT(lbl, prop, msg)
`define DMP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> hw/rtl/dmp_pkg.sv
// Shared types and constants of the DNS message parser.
// No dependencies; used by dmp_parser, dmp_out_stage and dns_message_parser.
package dmp_pkg;

  localparam int unsigned NAME_LIMIT = 255;
  localparam int unsigned NAME_LEN_W = 9;
  localparam logic [NAME_LEN_W-1:0] NAME_LEN_MAX = '1;
  localparam logic [7:0] LABEL_MAX = 8'd63;
  localparam logic [7:0] DOT_CHAR = 8'h2E;

  // Result kinds
  localparam logic [3:0] KIND_ID        = 4'd0;
  localparam logic [3:0] KIND_FLAGS     = 4'd1;
  localparam logic [3:0] KIND_QDCOUNT   = 4'd2;
  localparam logic [3:0] KIND_ANCOUNT   = 4'd3;
  localparam logic [3:0] KIND_NSCOUNT   = 4'd4;
  localparam logic [3:0] KIND_ARCOUNT   = 4'd5;
  localparam logic [3:0] KIND_NAME_CHAR = 4'd6;
  localparam logic [3:0] KIND_NAME_END  = 4'd7;
  localparam logic [3:0] KIND_TYPE      = 4'd8;
  localparam logic [3:0] KIND_CLASS     = 4'd9;
  localparam logic [3:0] KIND_TTL       = 4'd10;
  localparam logic [3:0] KIND_RDLENGTH  = 4'd11;
  localparam logic [3:0] KIND_ERROR     = 4'd12;

  // Error codes
  localparam logic [31:0] ERR_LONG      = 32'd0;
  localparam logic [31:0] ERR_TRUNCATED = 32'd1;
  localparam logic [31:0] ERR_BAD_LABEL = 32'd2;

  // Parser phases
  localparam logic [3:0] PH_HDR_ID      = 4'd0;
  localparam logic [3:0] PH_HDR_FLAGS   = 4'd1;
  localparam logic [3:0] PH_HDR_QD      = 4'd2;
  localparam logic [3:0] PH_HDR_AN      = 4'd3;
  localparam logic [3:0] PH_HDR_NS      = 4'd4;
  localparam logic [3:0] PH_HDR_AR      = 4'd5;
  localparam logic [3:0] PH_NAMELEN     = 4'd6;
  localparam logic [3:0] PH_LABEL       = 4'd7;
  localparam logic [3:0] PH_TYPE        = 4'd8;
  localparam logic [3:0] PH_CLASS       = 4'd9;
  localparam logic [3:0] PH_TTL         = 4'd10;
  localparam logic [3:0] PH_RDLEN       = 4'd11;
  localparam logic [3:0] PH_RDATA       = 4'd12;

  typedef struct packed {
    logic        valid;
    logic [3:0]  kind;
    logic [31:0] value;
    logic [1:0]  section;
    logic [15:0] record_number;
    logic        end_of_message;
  } result_t;

endpackage

>>> hw/rtl/dmp_parser.sv
// Parser state and next-state logic: one message byte per step, at most one result.
// Depends on dmp_pkg and dns_message_parser_defines.svh.
`include "dns_message_parser_defines.svh"

module dmp_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       in_byte,
  input  logic             in_first,
  input  logic             in_final,
  output dmp_pkg::result_t res
);

  logic [3:0]  phase_r, phase_nxt;
  logic [1:0]  fbc_r, fbc_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [1:0]  sec_r, sec_nxt;
  logic [15:0] rem_r [4];
  logic [15:0] rem_nxt [4];
  logic [15:0] idx_r, idx_nxt;
  logic [dmp_pkg::NAME_LEN_W-1:0] nlen_r, nlen_nxt;
  logic [5:0]  lbl_r, lbl_nxt;
  logic [15:0] rdl_r, rdl_nxt;
  logic        halted_r, halted_nxt;
  logic        active;

  function automatic logic [2:0] pick_section(logic [3:0] nz, logic [1:0] from);
    logic [2:0] r;
    r = 3'b000;
    for (int s = 3; s >= 0; s--) begin
      if ((2'(s) >= from) && nz[s]) r = {1'b1, 2'(s)};
    end
    return r;
  endfunction

  always_comb begin
    logic [31:0] acc_sh;
    logic [3:0]  ph_m2;
    logic [3:0]  nz;
    logic [2:0]  pk;
    logic        do_open;
    logic        rd_end;
    logic        done;
    logic        err;
    logic [31:0] ecode;
    logic        bad_phase;

    active = in_first | ~halted_r;
    if (in_first) begin
      phase_nxt = dmp_pkg::PH_HDR_ID;
      fbc_nxt   = '0;
      acc_nxt   = '0;
      sec_nxt   = '0;
      for (int s = 0; s < 4; s++) rem_nxt[s] = '0;
      idx_nxt   = '0;
      nlen_nxt  = '0;
      lbl_nxt   = '0;
      rdl_nxt   = '0;
    end else begin
      phase_nxt = phase_r;
      fbc_nxt   = fbc_r;
      acc_nxt   = acc_r;
      sec_nxt   = sec_r;
      for (int s = 0; s < 4; s++) rem_nxt[s] = rem_r[s];
      idx_nxt   = idx_r;
      nlen_nxt  = nlen_r;
      lbl_nxt   = lbl_r;
      rdl_nxt   = rdl_r;
    end
    halted_nxt = halted_r & ~in_first;

    res.valid          = 1'b0;
    res.kind           = dmp_pkg::KIND_ID;
    res.value          = '0;
    res.section        = sec_nxt;
    res.record_number  = idx_nxt;
    res.end_of_message = 1'b0;

    acc_sh    = {acc_nxt[23:0], in_byte};
    ph_m2     = phase_nxt - 4'd2;
    do_open   = 1'b0;
    rd_end    = 1'b0;
    done      = 1'b0;
    err       = 1'b0;
    ecode     = dmp_pkg::ERR_LONG;
    bad_phase = 1'b0;
    nz        = '0;
    pk        = '0;

    case (phase_nxt)
      dmp_pkg::PH_HDR_ID, dmp_pkg::PH_HDR_FLAGS, dmp_pkg::PH_HDR_QD,
      dmp_pkg::PH_HDR_AN, dmp_pkg::PH_HDR_NS, dmp_pkg::PH_HDR_AR: begin
        acc_nxt = acc_sh;
        if (fbc_nxt != 2'd0) begin
          fbc_nxt   = '0;
          res.valid = 1'b1;
          res.kind  = phase_nxt;
          res.value = {16'd0, acc_sh[15:0]};
          if (phase_nxt >= dmp_pkg::PH_HDR_QD) rem_nxt[ph_m2[1:0]] = acc_sh[15:0];
          if (phase_nxt == dmp_pkg::PH_HDR_AR) begin
            sec_nxt = '0;
            idx_nxt = '0;
            do_open = 1'b1;
          end else begin
            phase_nxt = phase_nxt + 4'd1;
          end
        end else begin
          fbc_nxt = fbc_nxt + 2'd1;
        end
      end
      dmp_pkg::PH_NAMELEN: begin
        if (32'(nlen_nxt) >= 32'(dmp_pkg::NAME_LIMIT)) begin
          err   = 1'b1;
          ecode = dmp_pkg::ERR_LONG;
        end else if (in_byte == 8'd0) begin
          res.valid = 1'b1;
          res.kind  = dmp_pkg::KIND_NAME_END;
          res.value = 32'(nlen_nxt);
          phase_nxt = dmp_pkg::PH_TYPE;
          fbc_nxt   = '0;
        end else if (in_byte > dmp_pkg::LABEL_MAX) begin
          err   = 1'b1;
          ecode = dmp_pkg::ERR_BAD_LABEL;
        end else begin
          if (nlen_nxt != '0) begin
            res.valid = 1'b1;
            res.kind  = dmp_pkg::KIND_NAME_CHAR;
            res.value = {24'd0, dmp_pkg::DOT_CHAR};
          end
          lbl_nxt   = in_byte[5:0];
          phase_nxt = dmp_pkg::PH_LABEL;
          if (nlen_nxt != dmp_pkg::NAME_LEN_MAX) begin
            nlen_nxt = nlen_nxt + {{(dmp_pkg::NAME_LEN_W-1){1'b0}}, 1'b1};
          end
        end
      end
      dmp_pkg::PH_LABEL: begin
        res.valid = 1'b1;
        res.kind  = dmp_pkg::KIND_NAME_CHAR;
        res.value = {24'd0, in_byte};
        if (nlen_nxt != dmp_pkg::NAME_LEN_MAX) begin
          nlen_nxt = nlen_nxt + {{(dmp_pkg::NAME_LEN_W-1){1'b0}}, 1'b1};
        end
        lbl_nxt = lbl_nxt - 6'd1;
        if (lbl_nxt == 6'd0) phase_nxt = dmp_pkg::PH_NAMELEN;
      end
      dmp_pkg::PH_TYPE: begin
        acc_nxt = acc_sh;
        if (fbc_nxt != 2'd0) begin
          fbc_nxt   = '0;
          res.valid = 1'b1;
          res.kind  = dmp_pkg::KIND_TYPE;
          res.value = {16'd0, acc_sh[15:0]};
          phase_nxt = dmp_pkg::PH_CLASS;
        end else begin
          fbc_nxt = fbc_nxt + 2'd1;
        end
      end
      dmp_pkg::PH_CLASS: begin
        acc_nxt = acc_sh;
        if (fbc_nxt != 2'd0) begin
          fbc_nxt   = '0;
          res.valid = 1'b1;
          res.kind  = dmp_pkg::KIND_CLASS;
          res.value = {16'd0, acc_sh[15:0]};
          if (sec_nxt == 2'd0) begin
            rem_nxt[sec_nxt] = rem_nxt[sec_nxt] - 16'd1;
            idx_nxt          = idx_nxt + 16'd1;
            do_open          = 1'b1;
          end else begin
            phase_nxt = dmp_pkg::PH_TTL;
          end
        end else begin
          fbc_nxt = fbc_nxt + 2'd1;
        end
      end
      dmp_pkg::PH_TTL: begin
        acc_nxt = acc_sh;
        if (fbc_nxt == 2'd3) begin
          fbc_nxt   = '0;
          res.valid = 1'b1;
          res.kind  = dmp_pkg::KIND_TTL;
          res.value = acc_sh;
          phase_nxt = dmp_pkg::PH_RDLEN;
        end else begin
          fbc_nxt = fbc_nxt + 2'd1;
        end
      end
      dmp_pkg::PH_RDLEN: begin
        acc_nxt = acc_sh;
        if (fbc_nxt != 2'd0) begin
          fbc_nxt   = '0;
          res.valid = 1'b1;
          res.kind  = dmp_pkg::KIND_RDLENGTH;
          res.value = {16'd0, acc_sh[15:0]};
          rdl_nxt   = acc_sh[15:0];
          if (acc_sh[15:0] == 16'd0) begin
            rem_nxt[sec_nxt] = rem_nxt[sec_nxt] - 16'd1;
            idx_nxt          = idx_nxt + 16'd1;
            do_open          = 1'b1;
          end else begin
            phase_nxt = dmp_pkg::PH_RDATA;
          end
        end else begin
          fbc_nxt = fbc_nxt + 2'd1;
        end
      end
      dmp_pkg::PH_RDATA: begin
        rdl_nxt = rdl_nxt - 16'd1;
        if (rdl_nxt == 16'd0) begin
          rem_nxt[sec_nxt] = rem_nxt[sec_nxt] - 16'd1;
          idx_nxt          = idx_nxt + 16'd1;
          do_open          = 1'b1;
          rd_end           = 1'b1;
        end
      end
      default: begin
        halted_nxt = 1'b1;
        bad_phase  = 1'b1;
      end
    endcase

    // Select the next entry, or finish the message when all counts are spent.
    for (int s = 0; s < 4; s++) nz[s] = (rem_nxt[s] != 16'd0);
    if (do_open) begin
      pk = pick_section(nz, sec_nxt);
      if (pk[2]) begin
        if (pk[1:0] != sec_nxt) begin
          sec_nxt = pk[1:0];
          idx_nxt = '0;
        end
        phase_nxt = dmp_pkg::PH_NAMELEN;
        nlen_nxt  = '0;
        fbc_nxt   = '0;
      end else begin
        halted_nxt = 1'b1;
        done       = 1'b1;
        if (rd_end) begin
          res.valid = 1'b1;
          res.kind  = dmp_pkg::KIND_RDLENGTH;
          res.value = {16'd0, acc_nxt[15:0]};
        end
      end
    end

    if (!bad_phase && (err || (!done && in_final))) begin
      halted_nxt = 1'b1;
      res.valid  = 1'b1;
      res.kind   = dmp_pkg::KIND_ERROR;
      res.value  = err ? ecode : dmp_pkg::ERR_TRUNCATED;
      done       = 1'b1;
    end
    res.end_of_message = done;

    if (!active) res.valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= dmp_pkg::PH_HDR_ID;
      fbc_r    <= '0;
      acc_r    <= '0;
      sec_r    <= '0;
      for (int s = 0; s < 4; s++) rem_r[s] <= '0;
      idx_r    <= '0;
      nlen_r   <= '0;
      lbl_r    <= '0;
      rdl_r    <= '0;
      halted_r <= 1'b1;
    end else if (step && active) begin
      phase_r  <= phase_nxt;
      fbc_r    <= fbc_nxt;
      acc_r    <= acc_nxt;
      sec_r    <= sec_nxt;
      for (int s = 0; s < 4; s++) rem_r[s] <= rem_nxt[s];
      idx_r    <= idx_nxt;
      nlen_r   <= nlen_nxt;
      lbl_r    <= lbl_nxt;
      rdl_r    <= rdl_nxt;
      halted_r <= halted_nxt;
    end
  end

  `DMP_ASSERT(a_name_end_under_limit, step && res.valid && res.kind == dmp_pkg::KIND_NAME_END |-> res.value < 32'(dmp_pkg::NAME_LIMIT), "name end reports length at or over limit")
  `DMP_ASSERT(a_halted_silent, step && halted_r && !in_first |=> $stable(phase_r) && halted_r, "halted parser changed state without a first byte")

endmodule

>>> hw/rtl/dmp_out_stage.sv
// Result register: holds one result until the downstream side takes it.
// Depends on dmp_pkg.
module dmp_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  dmp_pkg::result_t res,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [3:0]       out_kind,
  output logic [31:0]      out_value,
  output logic [1:0]       out_section,
  output logic [15:0]      out_record_number,
  output logic             out_end_of_message
);

  logic             out_v_r, out_v_nxt;
  dmp_pkg::result_t data_r;

  always_comb begin
    out_v_nxt = out_v_r;
    if (load && res.valid) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.valid) begin
      data_r <= res;
    end
  end

  assign out_valid          = out_v_r;
  assign out_kind           = data_r.kind;
  assign out_value          = data_r.value;
  assign out_section        = data_r.section;
  assign out_record_number  = data_r.record_number;
  assign out_end_of_message = data_r.end_of_message;

endmodule

>>> hw/rtl/dns_message_parser.sv
// DNS message parser top level: input register, parser, result register.
// Results are combinational on the input register and registered as the byte advances.
// Throughput 1 byte per cycle unless the output stalls; the parser update is combinational.
// Bytes that cause no result still take one slot through the input register.
// Reset (rst_n low, synchronous) empties both registers and halts the parser until a first byte.
// Depends on dmp_pkg, dmp_parser, dmp_out_stage.
`include "dns_message_parser_defines.svh"

module dns_message_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_msg_byte,
  input  logic        in_first_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_kind,
  output logic [31:0] out_value,
  output logic [1:0]  out_section,
  output logic [15:0] out_record_number,
  output logic        out_end_of_message
);

  logic             in_v_r, in_v_nxt;
  logic [7:0]       byte_r;
  logic             first_r;
  logic             final_r;
  logic             adv;
  dmp_pkg::result_t res;

  assign adv      = in_v_r && (!out_valid || !out_stall);
  assign in_stall = in_v_r && !adv;

  always_comb begin
    in_v_nxt = in_v_r;
    if (!in_stall) in_v_nxt = in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r  <= in_msg_byte;
      first_r <= in_first_byte;
      final_r <= in_final_byte;
    end
  end

  dmp_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (adv),
    .in_byte  (byte_r),
    .in_first (first_r),
    .in_final (final_r),
    .res      (res)
  );

  dmp_out_stage u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (adv),
    .res                (res),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_kind           (out_kind),
    .out_value          (out_value),
    .out_section        (out_section),
    .out_record_number  (out_record_number),
    .out_end_of_message (out_end_of_message)
  );

  `DMP_ASSERT(a_error_ends_message, out_valid && out_kind == dmp_pkg::KIND_ERROR |-> out_end_of_message, "error result without end of message")
  `DMP_ASSERT(a_stall_only_when_full, in_stall |-> in_v_r && out_valid && out_stall, "input stalled without a blocked held byte")
  `DMP_ASSERT(a_empty_after_reset, $past(!rst_n) |-> !out_valid && !in_stall, "pipeline not empty after reset")

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for dns_message_parser: directed byte table, then random messages.
// Results are predicted in-line and compared per transfer; depends on dmp_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int HALF_PERIOD = 4;
  localparam int HOLD_CYCLES = 40;
  localparam int ITEM_TARGET = 800;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] value;
    logic [1:0]  section;
    logic [15:0] rec;
    logic        eom;
  } dns_field_t;

  typedef struct packed {
    logic [7:0] b;
    logic       first;
    logic       last;
    logic       typed;
    dns_field_t want;
  } byte_row_t;

  typedef struct packed {
    byte_row_t r;
    logic      calm;
    logic      hold;
  } stim_row_t;

  localparam dns_field_t NO_RESULT = '0;

  localparam byte_row_t DIR_TAB [0:20] = '{
    '{8'h55, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, 1'b1, '{dmp_pkg::KIND_ID, 32'h0000FFFF, 2'd0, 16'd0, 1'b0}},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, 1'b1, '{dmp_pkg::KIND_FLAGS, 32'd0, 2'd0, 16'd0, 1'b0}},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, 1'b0, 1'b1, '{dmp_pkg::KIND_QDCOUNT, 32'd1, 2'd0, 16'd0, 1'b0}},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, 1'b0, 1'b1, '{dmp_pkg::KIND_ANCOUNT, 32'd1, 2'd0, 16'd0, 1'b0}},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, 1'b1, '{dmp_pkg::KIND_NSCOUNT, 32'd0, 2'd0, 16'd0, 1'b0}},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, 1'b1, '{dmp_pkg::KIND_ARCOUNT, 32'd0, 2'd0, 16'd0, 1'b0}},
    '{8'h00, 1'b0, 1'b0, 1'b1, '{dmp_pkg::KIND_NAME_END, 32'd0, 2'd0, 16'd0, 1'b0}},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h80, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h40, 1'b0, 1'b0, 1'b1,
      '{dmp_pkg::KIND_ERROR, dmp_pkg::ERR_BAD_LABEL, 2'd1, 16'd0, 1'b1}},
    '{8'h3F, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b1, 1'b1, 1'b1,
      '{dmp_pkg::KIND_ERROR, dmp_pkg::ERR_TRUNCATED, 2'd0, 16'd0, 1'b1}}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_msg_byte;
  logic        in_first_byte;
  logic        in_final_byte;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_kind;
  logic [31:0] out_value;
  logic [1:0]  out_section;
  logic [15:0] out_record_number;
  logic        out_end_of_message;

  stim_row_t  stim_q [$];
  dns_field_t parsed_q [$];
  int         mism = 0;
  bit         calm_now = 1'b0;
  bit         hold_req = 1'b0;

  // parser image
  logic [3:0]  pr_phase;
  int unsigned pr_nbytes;
  logic [31:0] pr_acc;
  logic [1:0]  pr_sec;
  logic [15:0] pr_left [4];
  logic [15:0] pr_idx;
  int unsigned pr_nlen;
  logic [5:0]  pr_lab;
  logic [15:0] pr_rd;
  bit          pr_halt;

  dns_message_parser u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_msg_byte        (in_msg_byte),
    .in_first_byte      (in_first_byte),
    .in_final_byte      (in_final_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_value          (out_value),
    .out_section        (out_section),
    .out_record_number  (out_record_number),
    .out_end_of_message (out_end_of_message)
  );

  always #HALF_PERIOD clk = ~clk;

  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic void parser_clear();
    pr_phase  = dmp_pkg::PH_HDR_ID;
    pr_nbytes = 0;
    pr_acc    = '0;
    pr_sec    = '0;
    for (int s = 0; s < 4; s++) pr_left[s] = '0;
    pr_idx    = '0;
    pr_nlen   = 0;
    pr_lab    = '0;
    pr_rd     = '0;
  endfunction

  function automatic bit shift_in(logic [7:0] b, int unsigned n);
    pr_acc = {pr_acc[23:0], b};
    if (pr_nbytes + 1 >= n) begin
      pr_nbytes = 0;
      return 1'b1;
    end
    pr_nbytes = (pr_nbytes + 1) & 3;
    return 1'b0;
  endfunction

  // picks the next entry with records left; 1 when the message is complete
  function automatic bit next_entry();
    for (int s = int'(pr_sec); s < 4; s++) begin
      if (pr_left[s] != 0) begin
        if (s != int'(pr_sec)) begin
          pr_sec = 2'(s);
          pr_idx = '0;
        end
        pr_phase  = dmp_pkg::PH_NAMELEN;
        pr_nlen   = 0;
        pr_nbytes = 0;
        return 1'b0;
      end
    end
    pr_halt = 1'b1;
    return 1'b1;
  endfunction

  function automatic bit close_entry();
    pr_left[pr_sec] = pr_left[pr_sec] - 16'd1;
    pr_idx = pr_idx + 16'd1;
    return next_entry();
  endfunction

  task automatic parse_byte(input logic [7:0] b, input bit first, input bit last,
                            output bit got, output dns_field_t res);
    bit          has;
    bit          done;
    bit          bad;
    logic [3:0]  kind;
    logic [31:0] val;
    logic [31:0] code;
    logic [1:0]  sec;
    logic [15:0] idx;
    got  = 1'b0;
    res  = NO_RESULT;
    has  = 1'b0;
    done = 1'b0;
    bad  = 1'b0;
    kind = '0;
    val  = '0;
    code = dmp_pkg::ERR_LONG;
    if (first) begin
      parser_clear();
      pr_halt = 1'b0;
    end else if (pr_halt) begin
      return;
    end
    sec = pr_sec;
    idx = pr_idx;
    case (pr_phase)
      dmp_pkg::PH_HDR_ID, dmp_pkg::PH_HDR_FLAGS, dmp_pkg::PH_HDR_QD,
      dmp_pkg::PH_HDR_AN, dmp_pkg::PH_HDR_NS, dmp_pkg::PH_HDR_AR: begin
        if (shift_in(b, 2)) begin
          has  = 1'b1;
          kind = pr_phase;
          val  = {16'd0, pr_acc[15:0]};
          if (pr_phase >= dmp_pkg::PH_HDR_QD) begin
            pr_left[2'(pr_phase - dmp_pkg::PH_HDR_QD)] = pr_acc[15:0];
          end
          if (pr_phase == dmp_pkg::PH_HDR_AR) begin
            pr_sec = '0;
            pr_idx = '0;
            done   = next_entry();
          end else begin
            pr_phase = pr_phase + 4'd1;
          end
        end
      end
      dmp_pkg::PH_NAMELEN: begin
        if (pr_nlen >= dmp_pkg::NAME_LIMIT) begin
          bad  = 1'b1;
          code = dmp_pkg::ERR_LONG;
        end else if (b == 8'd0) begin
          has       = 1'b1;
          kind      = dmp_pkg::KIND_NAME_END;
          val       = 32'(pr_nlen);
          pr_phase  = dmp_pkg::PH_TYPE;
          pr_nbytes = 0;
        end else if (b > dmp_pkg::LABEL_MAX) begin
          bad  = 1'b1;
          code = dmp_pkg::ERR_BAD_LABEL;
        end else begin
          if (pr_nlen != 0) begin
            has  = 1'b1;
            kind = dmp_pkg::KIND_NAME_CHAR;
            val  = {24'd0, dmp_pkg::DOT_CHAR};
          end
          pr_lab   = b[5:0];
          pr_phase = dmp_pkg::PH_LABEL;
          if (pr_nlen < dmp_pkg::NAME_LEN_MAX) pr_nlen++;
        end
      end
      dmp_pkg::PH_LABEL: begin
        has  = 1'b1;
        kind = dmp_pkg::KIND_NAME_CHAR;
        val  = {24'd0, b};
        if (pr_nlen < dmp_pkg::NAME_LEN_MAX) pr_nlen++;
        pr_lab = pr_lab - 6'd1;
        if (pr_lab == 6'd0) pr_phase = dmp_pkg::PH_NAMELEN;
      end
      dmp_pkg::PH_TYPE: begin
        if (shift_in(b, 2)) begin
          has      = 1'b1;
          kind     = dmp_pkg::KIND_TYPE;
          val      = {16'd0, pr_acc[15:0]};
          pr_phase = dmp_pkg::PH_CLASS;
        end
      end
      dmp_pkg::PH_CLASS: begin
        if (shift_in(b, 2)) begin
          has  = 1'b1;
          kind = dmp_pkg::KIND_CLASS;
          val  = {16'd0, pr_acc[15:0]};
          if (sec == 2'd0) done = close_entry();
          else pr_phase = dmp_pkg::PH_TTL;
        end
      end
      dmp_pkg::PH_TTL: begin
        if (shift_in(b, 4)) begin
          has      = 1'b1;
          kind     = dmp_pkg::KIND_TTL;
          val      = pr_acc;
          pr_phase = dmp_pkg::PH_RDLEN;
        end
      end
      dmp_pkg::PH_RDLEN: begin
        if (shift_in(b, 2)) begin
          has   = 1'b1;
          kind  = dmp_pkg::KIND_RDLENGTH;
          val   = {16'd0, pr_acc[15:0]};
          pr_rd = pr_acc[15:0];
          if (pr_rd == 16'd0) done = close_entry();
          else pr_phase = dmp_pkg::PH_RDATA;
        end
      end
      dmp_pkg::PH_RDATA: begin
        pr_rd = pr_rd - 16'd1;
        if (pr_rd == 16'd0) begin
          done = close_entry();
          // closing rdlength marker when the rdata ends the message
          if (done) begin
            has  = 1'b1;
            kind = dmp_pkg::KIND_RDLENGTH;
            val  = {16'd0, pr_acc[15:0]};
          end
        end
      end
      default: begin
        pr_halt = 1'b1;
        return;
      end
    endcase
    if (bad || (!done && last)) begin
      pr_halt = 1'b1;
      has     = 1'b1;
      kind    = dmp_pkg::KIND_ERROR;
      val     = bad ? code : dmp_pkg::ERR_TRUNCATED;
      done    = 1'b1;
    end
    if (has) begin
      got = 1'b1;
      res = '{kind, val, sec, idx, done};
    end
  endtask

  // flaw: 1 bad label, 2 long name, consumed by the first name built
  task automatic add_name(ref logic [7:0] m [$], inout int flaw);
    int labels;
    int len;
    if (flaw == 2) begin
      for (int l = 0; l < 4; l++) begin
        len = (l < 3) ? 63 : $urandom_range(61, 63);
        m.push_back(8'(len));
        repeat (len) m.push_back(8'($urandom));
      end
      m.push_back(8'd0);
      flaw = 0;
      return;
    end
    if (flaw == 1) begin
      m.push_back(8'($urandom_range(64, 255)));
      flaw = 0;
      return;
    end
    labels = $urandom_range(0, 3);
    for (int l = 0; l < labels; l++) begin
      len = ($urandom_range(0, 15) == 0) ? 63 : $urandom_range(1, 8);
      m.push_back(8'(len));
      repeat (len) m.push_back(8'($urandom));
    end
    m.push_back(8'd0);
  endtask

  task automatic push_u16(ref logic [7:0] m [$], input logic [15:0] v);
    m.push_back(v[15:8]);
    m.push_back(v[7:0]);
  endtask

  // mode: 0-6 clean, 7 truncated, 8 bad label, 9 long name, 10 restart mid-message
  task automatic add_message(input int msg_no);
    logic [7:0]  m [$];
    logic [15:0] cnt [4];
    logic [15:0] rdl;
    logic [31:0] ttl;
    int          mode;
    int          flaw;
    int          cut;
    bit          calm;
    bit          last_mark;
    bit          truncated;
    mode      = $urandom_range(0, 10);
    flaw      = (mode == 8) ? 1 : (mode == 9) ? 2 : 0;
    calm      = ($urandom_range(0, 5) == 0);
    truncated = (mode == 7) || (mode == 10);
    last_mark = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) == 0) begin
      foreach (cnt[s]) cnt[s] = '0;
    end else begin
      cnt[0] = 16'($urandom_range(0, 2));
      cnt[1] = 16'($urandom_range(0, 2));
      cnt[2] = 16'($urandom_range(0, 1));
      cnt[3] = 16'($urandom_range(0, 2));
    end
    push_u16(m, 16'($urandom));
    push_u16(m, 16'($urandom));
    for (int s = 0; s < 4; s++) begin
      if (mode == 7 && s == 0 && $urandom_range(0, 1)) push_u16(m, 16'hFFFF);
      else push_u16(m, cnt[s]);
    end
    for (int q = 0; q < cnt[0]; q++) begin
      add_name(m, flaw);
      push_u16(m, 16'($urandom));
      push_u16(m, 16'($urandom));
    end
    for (int rr = 0; rr < cnt[1] + cnt[2] + cnt[3]; rr++) begin
      add_name(m, flaw);
      push_u16(m, 16'($urandom));
      push_u16(m, 16'($urandom));
      case ($urandom_range(0, 3))
        0:       ttl = 32'd0;
        1:       ttl = 32'hFFFF_FFFF;
        default: ttl = $urandom;
      endcase
      push_u16(m, ttl[31:16]);
      push_u16(m, ttl[15:0]);
      rdl = 16'($urandom_range(0, 4));
      push_u16(m, rdl);
      repeat (rdl) m.push_back(8'($urandom));
    end
    cut = truncated ? $urandom_range(1, m.size() - 1) : m.size();
    for (int i = 0; i < cut; i++) begin
      stim_q.push_back('{'{m[i], i == 0,
                         (i == cut - 1) && (mode == 7 || (!truncated && last_mark)),
                         1'b0, NO_RESULT},
                        calm, (i == 0) && (msg_no == 3 || msg_no == 12)});
    end
    // trailing bytes after completion are ignored
    if (!truncated && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        stim_q.push_back('{'{8'($urandom), 1'b0, 1'($urandom), 1'b0, NO_RESULT}, calm, 1'b0});
      end
    end
  endtask

  task automatic flag_error(input string what, input dns_field_t want, input dns_field_t seen);
    mism++;
    if (mism <= 10) begin
      $display("%0t %s: exp kind %0d val %h sec %0d rec %0d eom %0b", $time, what,
               want.kind, want.value, want.section, want.rec, want.eom);
      $display("%0t %s: got kind %0d val %h sec %0d rec %0d eom %0b", $time, what,
               seen.kind, seen.value, seen.section, seen.rec, seen.eom);
    end
  endtask

  initial begin : driver
    stim_row_t  row;
    bit         got;
    dns_field_t res;
    int         gap;
    int         msg_no;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_msg_byte   = '0;
    in_first_byte = 1'b0;
    in_final_byte = 1'b0;
    parser_clear();
    pr_halt = 1'b1;
    foreach (DIR_TAB[i]) stim_q.push_back('{DIR_TAB[i], 1'b0, 1'b0});
    msg_no = 0;
    while (stim_q.size() < ITEM_TARGET + $size(DIR_TAB)) begin
      add_message(msg_no);
      msg_no++;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (stim_q.size() != 0) begin
      row      = stim_q.pop_front();
      calm_now = row.calm;
      if (row.hold) hold_req = 1'b1;
      gap = row.calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid      <= 1'b1;
      in_msg_byte   <= row.r.b;
      in_first_byte <= row.r.first;
      in_final_byte <= row.r.last;
      do @(posedge clk); while (!(in_valid && in_stall === 1'b0));
      parse_byte(row.r.b, row.r.first, row.r.last, got, res);
      if (row.r.typed) parsed_q.push_back(row.r.want);
      else if (got) parsed_q.push_back(res);
    end
    in_valid <= 1'b0;
    calm_now = 1'b0;
    while (parsed_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mism == 0 && parsed_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : receiver
    int w;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        w        = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        w = calm_now ? 0 : $urandom_range(0, 3);
      end
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && !out_stall));
    end
  end

  always @(posedge clk) begin : monitor
    dns_field_t seen;
    dns_field_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && !out_stall) begin
      seen = '{out_kind, out_value, out_section, out_record_number, out_end_of_message};
      if (parsed_q.size() == 0) begin
        flag_error("unexpected transfer", NO_RESULT, seen);
      end else begin
        want = parsed_q.pop_front();
        if (seen.kind !== want.kind || seen.value !== want.value ||
            seen.section !== want.section || seen.rec !== want.rec ||
            seen.eom !== want.eom) begin
          flag_error("mismatch", want, seen);
        end
      end
    end
  end

endmodule
